FILE: design/psq_pkg.sv
// ----------------------------------------------------------------------------
// psq_pkg
// shared types and constants of the priority sequence queue
// ----------------------------------------------------------------------------
`default_nettype none

package psq_pkg;

    typedef enum logic [1:0] {
        FUNC_ENQUEUE = 2'd0,
        FUNC_REMOVE  = 2'd1,
        FUNC_CLEAR   = 2'd2
    } psq_func_t;

    typedef enum logic [1:0] {
        ACT_NONE       = 2'd0,
        ACT_START      = 2'd1,
        ACT_STOP       = 2'd2,
        ACT_STOP_START = 2'd3
    } psq_action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_RESULT
    } psq_state_t;

    localparam logic CFG_START_DISABLED = 1'b0;
    localparam logic CFG_EFFECTS_PLAYER = 1'b1;

    localparam logic [1:0] EFFECTS_PLAYER_RESET = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic [1:0] player;
        logic [7:0] seq_id;
        logic [7:0] priority_req;
        logic [7:0] fade;
    } psq_in_t;

    typedef struct packed {
        psq_action_t action;
        logic [1:0]  out_player;
        logic [7:0]  start_seq;
        logic [6:0]  start_priority;
        logic [7:0]  out_fade;
        logic [2:0]  queue_count;
    } psq_out_t;

    typedef struct packed {
        logic [7:0] id;
        logic [7:0] prio;
    } psq_entry_t;

    typedef struct packed {
        logic       scan;
        logic       ins;
        logic       rem;
        logic [1:0] player;
        logic [7:0] seq_id;
        logic [7:0] prio;
    } psq_ctl_t;

endpackage

`default_nettype wire

FILE: design/psq_cell.sv
// ----------------------------------------------------------------------------
// psq_cell
// one queue position for every player: compares against the command and
// shifts in from the left neighbour on insert or from the right on removal
// ----------------------------------------------------------------------------
`default_nettype none

module psq_cell
    import psq_pkg::*;
#(
    parameter int NUM_PLAYERS = 4
)
(
    input  wire logic       clk,
    input  wire psq_ctl_t   ctl,
    input  wire logic       slot_valid,
    input  wire psq_entry_t left_entry,
    input  wire logic       left_ge,
    input  wire logic       left_after,
    input  wire psq_entry_t right_entry,
    output psq_entry_t      entry,
    output logic            ge,
    output logic            after,
    output logic            match
);

    localparam int PW = (NUM_PLAYERS > 1) ? $clog2(NUM_PLAYERS) : 1;

    psq_entry_t       entry_reg [NUM_PLAYERS];
    psq_entry_t       entry_next;
    logic             match_reg;
    logic             ge_reg;
    logic [PW-1:0]    pidx;
    psq_entry_t       new_entry;

    assign pidx      = PW'(ctl.player);
    assign entry     = entry_reg[pidx];
    assign new_entry = '{id: ctl.seq_id, prio: ctl.prio};
    assign ge        = ge_reg;
    assign match     = match_reg;
    assign after     = match_reg | left_after;

    always_ff @(posedge clk)
    begin
        if (ctl.scan)
        begin
            match_reg <= slot_valid && (entry.id == ctl.seq_id);
            ge_reg    <= !slot_valid || (entry.prio <= ctl.prio);
        end
    end

    always_comb
    begin
        entry_next = entry;
        if (ctl.ins)
        begin
            if (left_ge)
                entry_next = left_entry;
            else if (ge_reg)
                entry_next = new_entry;
        end
        else if (ctl.rem && after)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ins || ctl.rem)
            entry_reg[pidx] <= entry_next;
    end

endmodule

`default_nettype wire

FILE: design/priority_sequence_queue.sv
// a result is offered once the scan, apply and result steps have run in turn;
//   a new command is taken only after the last one leaves the result step, and
//   each step acts on the whole row of queue cells, one position per cell
// a waiting result does not block the next command from being accepted
// reset clears the fill counts, configuration and control; queue entries
//   hold no reset value and are only read below the fill count
// ----------------------------------------------------------------------------
// priority_sequence_queue
// per-player sorted queue of sequence ids with start and stop results
// ----------------------------------------------------------------------------
`default_nettype none

module priority_sequence_queue
    import psq_pkg::*;
#(
    parameter int NUM_PLAYERS = 4,
    parameter int QUEUE_DEPTH = 5
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cmd_valid,
    output logic            cmd_ready,
    input  wire psq_in_t    cmd,
    output logic            rsp_valid,
    input  wire logic       rsp_ready,
    output psq_out_t        rsp,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [1:0] cfg_data
);

    localparam int PW = (NUM_PLAYERS > 1) ? $clog2(NUM_PLAYERS) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    psq_state_t      state_reg;
    psq_state_t      state_next;
    psq_in_t         cmd_reg;
    psq_out_t        rsp_reg;
    psq_out_t        rsp_next;
    logic            rsp_valid_reg;
    logic            start_disabled_reg;
    logic [1:0]      effects_player_reg;
    logic [CW-1:0]   count_reg [NUM_PLAYERS];
    logic [CW-1:0]   count_next;
    logic [CW-1:0]   cnt_reg;
    psq_action_t     act_reg;
    psq_action_t     act_next;
    logic            ins_en;
    logic            rem_en;
    logic            upd_en;
    logic [PW-1:0]   pidx;
    logic            player_ok;
    logic            may_start;
    logic [CW-1:0]   n;
    logic            load_rsp;
    psq_ctl_t        ctl;

    psq_entry_t      cell_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_ge;
    logic [QUEUE_DEPTH-1:0] cell_after;
    logic [QUEUE_DEPTH-1:0] cell_match;
    logic [QUEUE_DEPTH-1:0] slot_valid;

    assign pidx      = PW'(cmd_reg.player);
    assign player_ok = 32'(cmd_reg.player) < NUM_PLAYERS;
    assign n         = count_reg[pidx];
    assign may_start = !start_disabled_reg || (cmd_reg.player == effects_player_reg);

    // cell row
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        psq_entry_t left_entry;
        logic       left_ge;
        logic       left_after;
        psq_entry_t right_entry;

        assign slot_valid[i] = CW'(i) < n;

        if (i == 0)
        begin : g_first
            assign left_entry = '0;
            assign left_ge    = 1'b0;
            assign left_after = 1'b0;
        end
        else
        begin : g_inner
            assign left_entry = cell_entry[i-1];
            assign left_ge    = cell_ge[i-1];
            assign left_after = cell_after[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_mid
            assign right_entry = cell_entry[i+1];
        end

        psq_cell #(
            .NUM_PLAYERS (NUM_PLAYERS)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .slot_valid  (slot_valid[i]),
            .left_entry  (left_entry),
            .left_ge     (left_ge),
            .left_after  (left_after),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .ge          (cell_ge[i]),
            .after       (cell_after[i]),
            .match       (cell_match[i])
        );
    end

    // command decision from the scan flags
    always_comb
    begin
        ins_en     = 1'b0;
        rem_en     = 1'b0;
        upd_en     = 1'b0;
        act_next   = ACT_NONE;
        count_next = n;
        if (!player_ok)
        begin
            count_next = '0;
        end
        else
        begin
            unique case (cmd_reg.func)
                FUNC_ENQUEUE:
                begin
                    if (|cell_match)
                    begin
                        if (cell_match[0] && may_start)
                            act_next = ACT_START;
                    end
                    else if (cell_ge[QUEUE_DEPTH-1])
                    begin
                        ins_en = 1'b1;
                        upd_en = 1'b1;
                        if (n != CW'(QUEUE_DEPTH))
                            count_next = n + CW'(1);
                        if (cell_ge[0] && may_start)
                            act_next = ACT_START;
                    end
                end
                FUNC_REMOVE:
                begin
                    if (|cell_match)
                    begin
                        rem_en     = 1'b1;
                        upd_en     = 1'b1;
                        count_next = n - CW'(1);
                    end
                    if (cell_match[0] || (n == '0))
                    begin
                        if ((count_next != '0) && may_start)
                            act_next = ACT_STOP_START;
                        else
                            act_next = ACT_STOP;
                    end
                end
                FUNC_CLEAR:
                begin
                    upd_en     = 1'b1;
                    count_next = '0;
                end
                default:
                begin
                    act_next = ACT_NONE;
                end
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (cmd_valid)
                    state_next = ST_SCAN;
            ST_SCAN:
                state_next = ST_APPLY;
            ST_APPLY:
                state_next = ST_RESULT;
            ST_RESULT:
                if (!rsp_valid_reg || rsp_ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        cmd_ready  = 1'b0;
        load_rsp   = 1'b0;
        ctl.scan   = 1'b0;
        ctl.ins    = 1'b0;
        ctl.rem    = 1'b0;
        ctl.player = cmd_reg.player;
        ctl.seq_id = cmd_reg.seq_id;
        ctl.prio   = cmd_reg.priority_req;
        unique case (state_reg)
            ST_IDLE:
                cmd_ready = 1'b1;
            ST_SCAN:
                ctl.scan = 1'b1;
            ST_APPLY:
            begin
                ctl.ins = ins_en;
                ctl.rem = rem_en;
            end
            ST_RESULT:
                load_rsp = !rsp_valid_reg || rsp_ready;
            default:
                cmd_ready = 1'b0;
        endcase
    end

    // result item
    always_comb
    begin
        rsp_next                = '0;
        rsp_next.action         = act_reg;
        rsp_next.out_player     = cmd_reg.player;
        rsp_next.queue_count    = 3'(cnt_reg);
        if (act_reg != ACT_NONE)
            rsp_next.out_fade = cmd_reg.fade;
        if (act_reg == ACT_START)
        begin
            rsp_next.start_seq      = cmd_reg.seq_id;
            rsp_next.start_priority = cmd_reg.priority_req[6:0];
        end
        else if (act_reg == ACT_STOP_START)
        begin
            rsp_next.start_seq      = cell_entry[0].id;
            rsp_next.start_priority = cell_entry[0].prio[6:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            rsp_valid_reg      <= 1'b0;
            start_disabled_reg <= 1'b0;
            effects_player_reg <= EFFECTS_PLAYER_RESET;
            for (int p = 0; p < NUM_PLAYERS; p++)
                count_reg[p] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_rsp)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_START_DISABLED: start_disabled_reg <= cfg_data[0];
                    CFG_EFFECTS_PLAYER: effects_player_reg <= cfg_data;
                    default:            start_disabled_reg <= start_disabled_reg;
                endcase
            end
            if ((state_reg == ST_APPLY) && upd_en)
                count_reg[pidx] <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
            cmd_reg <= cmd;
        if (state_reg == ST_APPLY)
        begin
            act_reg <= act_next;
            cnt_reg <= count_next;
        end
        if (load_rsp)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

FILE: design/psq_checker.sv
// ----------------------------------------------------------------------------
// psq_checker
// port-level checks of the priority sequence queue
// ----------------------------------------------------------------------------
`default_nettype none

module psq_checker
    import psq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 5
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cmd_valid,
    input  wire logic       cmd_ready,
    input  wire logic       rsp_valid,
    input  wire logic       rsp_ready,
    input  wire psq_out_t   rsp
);

    // a stalled result item holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result item changed while stalled");

    // one command item at a time
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command item taken while another is in work");

    // no start fields or fade without an action
    a_none_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.action == ACT_NONE) |->
            (rsp.out_fade == 8'd0) && (rsp.start_seq == 8'd0)
            && (rsp.start_priority == 7'd0))
        else $error("idle result carries data");

    // a plain stop names no sequence
    a_stop_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.action == ACT_STOP) |->
            (rsp.start_seq == 8'd0) && (rsp.start_priority == 7'd0))
        else $error("stop result carries a start");

    // fill count stays within the queue
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (32'(rsp.queue_count) <= QUEUE_DEPTH)
            || (QUEUE_DEPTH > 7))
        else $error("queue count beyond depth");

endmodule

bind priority_sequence_queue psq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_psq_checker (.*);

`default_nettype wire
